// File: rtl/core/barometric_compensation_top_assert.svh
// ----------------------------------------------------------------------------
// barometric compensation assertion macros
// concurrent checks that vanish when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef BAROMETRIC_COMPENSATION_TOP_ASSERT_SVH
`define BAROMETRIC_COMPENSATION_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// property holds at every clock edge outside reset
`define BC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("barometric compensation check failed");
// consequent holds in the cycle after the antecedent
`define BC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("barometric compensation check failed");
`else
`define BC_ASSERT(lbl, clk, rstn, prop)
`define BC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/core/bcomp_pkg.sv
// ----------------------------------------------------------------------------
// bcomp_pkg
// shared types, codes and arithmetic helpers of the barometric compensation
// ----------------------------------------------------------------------------
package bcomp_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_AC1_AC2 = 3'd0;
    localparam logic [2:0] REG_AC3_AC4 = 3'd1;
    localparam logic [2:0] REG_AC5_AC6 = 3'd2;
    localparam logic [2:0] REG_B1_B2   = 3'd3;
    localparam logic [2:0] REG_MC_MD   = 3'd4;
    localparam logic [2:0] REG_OSS     = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    // queued request
    typedef struct packed {
        logic [15:0] raw_temp;
        logic [23:0] raw_press;
    } t_item;

    // calibration set seen by the back end
    typedef struct packed {
        logic [31:0] ac1_ac2;
        logic [31:0] ac3_ac4;
        logic [31:0] ac5_ac6;
        logic [31:0] b1_b2;
        logic [31:0] mc_md;
        logic [1:0]  oss;
    } t_cal;

    // sign extension of a 16-bit coefficient
    function automatic logic [31:0] sx16(input logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

    // signed division by 2^k truncating toward zero
    function automatic logic [31:0] sdp(input logic [31:0] a, input logic [4:0] k);
        logic [31:0] bias;
        logic [31:0] s;
        bias = a[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
        s    = a + bias;
        return 32'($signed(s) >>> k);
    endfunction

endpackage

// File: rtl/core/bcomp_front.sv
// ----------------------------------------------------------------------------
// bcomp_front
// accepts requests and holds them in a two-entry queue for the back end
// ----------------------------------------------------------------------------
module bcomp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [15:0]      i_raw_temp,
    input  logic [23:0]      i_raw_press,
    output logic             o_busy,
    input  logic             i_pop,
    output logic             o_avail,
    output bcomp_pkg::t_item o_item
);
    import bcomp_pkg::*;

    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_busy  = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign push    = i_start && !o_busy;
    assign pop     = i_pop && o_avail;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= '{raw_temp: i_raw_temp, raw_press: i_raw_press};
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// File: rtl/core/bcomp_div.sv
// ----------------------------------------------------------------------------
// bcomp_div
// unsigned 32-bit restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bcomp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quot
);
    logic        r_busy, r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem, r_quo, r_div;
    logic [32:0] trial, diff;

    // one restoring step
    always_comb begin
        trial = {r_rem, r_quo[31]};
        diff  = trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= 32'd0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            if (!diff[32]) begin
                r_rem <= diff[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= trial[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule

// File: rtl/core/bcomp_back.sv
// ----------------------------------------------------------------------------
// bcomp_back
// sequencer that runs the compensation formulas on one shared multiplier
// and one shared divider
// ----------------------------------------------------------------------------
`include "barometric_compensation_top_assert.svh"

module bcomp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bcomp_pkg::t_cal  i_cal,
    input  logic             i_avail,
    input  bcomp_pkg::t_item i_item,
    output logic             o_pop,
    output logic             o_valid,
    output logic [15:0]      o_temperature,
    output logic [19:0]      o_pressure,
    output logic [1:0]       o_status
);
    import bcomp_pkg::*;

    typedef enum logic [18:0] {
        S_IDLE = 19'(1 << 0),
        S_T1   = 19'(1 << 1),
        S_T2   = 19'(1 << 2),
        S_TDIV = 19'(1 << 3),
        S_T3   = 19'(1 << 4),
        S_P1   = 19'(1 << 5),
        S_P2   = 19'(1 << 6),
        S_P3   = 19'(1 << 7),
        S_P4   = 19'(1 << 8),
        S_P5   = 19'(1 << 9),
        S_P6   = 19'(1 << 10),
        S_P7   = 19'(1 << 11),
        S_P8   = 19'(1 << 12),
        S_P9   = 19'(1 << 13),
        S_PDIV = 19'(1 << 14),
        S_P10  = 19'(1 << 15),
        S_P11  = 19'(1 << 16),
        S_P12  = 19'(1 << 17),
        S_P13  = 19'(1 << 18)
    } t_state;

    t_state      r_state;
    logic [15:0] r_ut, r_tout;
    logic [31:0] r_up, r_x1, r_x2, r_b6, r_sq, r_b3, r_b4, r_p;
    logic        r_neg, r_post, r_valid;
    logic [19:0] r_pout;
    logic [1:0]  r_status;

    // coefficient fields
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = sx16(i_cal.ac1_ac2[31:16]);
    assign ac2 = sx16(i_cal.ac1_ac2[15:0]);
    assign ac3 = sx16(i_cal.ac3_ac4[31:16]);
    assign ac4 = {16'd0, i_cal.ac3_ac4[15:0]};
    assign ac5 = {16'd0, i_cal.ac5_ac6[31:16]};
    assign ac6 = {16'd0, i_cal.ac5_ac6[15:0]};
    assign b1  = sx16(i_cal.b1_b2[31:16]);
    assign b2  = sx16(i_cal.b1_b2[15:0]);
    assign mc  = sx16(i_cal.mc_md[31:16]);
    assign md  = sx16(i_cal.mc_md[15:0]);

    // shared multiplier operand selection
    logic [31:0] mul_a, mul_b, prod;
    logic [63:0] prod_w;
    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (r_state)
            S_T1:  begin mul_a = {16'd0, r_ut} - ac6; mul_b = ac5; end
            S_P1:  begin mul_a = r_b6; mul_b = r_b6; end
            S_P2:  begin mul_a = b2; mul_b = r_sq; end
            S_P3:  begin mul_a = ac2; mul_b = r_b6; end
            S_P5:  begin mul_a = ac3; mul_b = r_b6; end
            S_P6:  begin mul_a = b1; mul_b = r_sq; end
            S_P7:  begin mul_a = ac4; mul_b = sdp(r_x1 + r_x2 + 32'd2, 5'd2) + 32'd32768; end
            S_P8:  begin mul_a = r_up - r_b3; mul_b = 32'd50000 >> i_cal.oss; end
            S_P10: begin mul_a = sdp(r_p, 5'd8); mul_b = sdp(r_p, 5'd8); end
            S_P11: begin mul_a = r_x1; mul_b = 32'd3038; end
            S_P12: begin mul_a = 32'd0 - 32'd7357; mul_b = r_p; end
            default: begin mul_a = 32'd0; mul_b = 32'd0; end
        endcase
        prod_w = mul_a * mul_b;
        prod   = prod_w[31:0];
    end

    // divider hookup
    logic        div_start, div_done;
    logic [31:0] div_a, div_b, div_q;
    logic [31:0] den, sdiv_a;
    assign den    = r_x1 + md;
    assign sdiv_a = mc << 11;

    always_comb begin
        div_start = 1'b0;
        div_a     = 32'd0;
        div_b     = 32'd0;
        if (r_state == S_T2 && den != 32'd0) begin
            div_start = 1'b1;
            div_a     = sdiv_a[31] ? 32'd0 - sdiv_a : sdiv_a;
            div_b     = den[31] ? 32'd0 - den : den;
        end else if (r_state == S_P9) begin
            div_start = 1'b1;
            div_a     = r_p[31] ? r_p : (r_p << 1);
            div_b     = r_b4;
        end
    end

    bcomp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // per-step results
    logic [31:0] x2q, b5, t, x3b, b3_pre, pfin;
    always_comb begin
        x2q    = r_neg ? 32'd0 - div_q : div_q;
        b5     = r_x1 + r_x2;
        t      = sdp(b5 + 32'd8, 5'd4);
        x3b    = ((ac1 << 2) + r_x1 + r_x2) << i_cal.oss;
        b3_pre = sdp(x3b + 32'd2, 5'd2);
        pfin   = r_p + sdp(r_x1 + r_x2 + 32'd3791, 5'd4);
    end

    assign o_pop = (r_state == S_IDLE) && i_avail;

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_avail) begin
                        r_ut    <= i_item.raw_temp;
                        r_up    <= 32'({8'd0, i_item.raw_press} >> (4'd8 - {2'd0, i_cal.oss}));
                        r_state <= S_T1;
                    end
                end
                S_T1: begin
                    r_x1    <= sdp(prod, 5'd15);
                    r_state <= S_T2;
                end
                S_T2: begin
                    if (den == 32'd0) begin
                        r_tout   <= 16'd0;
                        r_pout   <= 20'd0;
                        r_status <= ST_DIVZ;
                        r_valid  <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_neg   <= sdiv_a[31] ^ den[31];
                        r_state <= S_TDIV;
                    end
                end
                S_TDIV: begin
                    if (div_done) begin
                        r_x2    <= x2q;
                        r_state <= S_T3;
                    end
                end
                S_T3: begin
                    r_b6 <= b5 - 32'd4000;
                    if ($signed(t) < -32'sd32768) begin
                        r_tout   <= 16'h8000;
                        r_status <= ST_SAT;
                    end else if ($signed(t) > 32'sd32767) begin
                        r_tout   <= 16'h7fff;
                        r_status <= ST_SAT;
                    end else begin
                        r_tout   <= t[15:0];
                        r_status <= ST_OK;
                    end
                    r_state <= S_P1;
                end
                S_P1: begin
                    r_sq    <= sdp(prod, 5'd12);
                    r_state <= S_P2;
                end
                S_P2: begin
                    r_x1    <= sdp(prod, 5'd11);
                    r_state <= S_P3;
                end
                S_P3: begin
                    r_x2    <= sdp(prod, 5'd11);
                    r_state <= S_P4;
                end
                S_P4: begin
                    r_b3    <= b3_pre;
                    r_state <= S_P5;
                end
                S_P5: begin
                    r_x1    <= sdp(prod, 5'd15);
                    r_state <= S_P6;
                end
                S_P6: begin
                    r_x2    <= sdp(prod, 5'd16);
                    r_state <= S_P7;
                end
                S_P7: begin
                    r_b4    <= prod >> 15;
                    r_state <= S_P8;
                end
                S_P8: begin
                    if (r_b4 == 32'd0) begin
                        r_pout   <= 20'd0;
                        r_status <= ST_DIVZ;
                        r_valid  <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_p     <= prod;
                        r_state <= S_P9;
                    end
                end
                S_P9: begin
                    r_post  <= r_p[31];
                    r_state <= S_PDIV;
                end
                S_PDIV: begin
                    if (div_done) begin
                        r_p     <= r_post ? (div_q << 1) : div_q;
                        r_state <= S_P10;
                    end
                end
                S_P10: begin
                    r_x1    <= prod;
                    r_state <= S_P11;
                end
                S_P11: begin
                    r_x1    <= sdp(prod, 5'd16);
                    r_state <= S_P12;
                end
                S_P12: begin
                    r_x2    <= sdp(prod, 5'd16);
                    r_state <= S_P13;
                end
                S_P13: begin
                    if (pfin[31]) begin
                        r_pout   <= 20'd0;
                        r_status <= ST_SAT;
                    end else if (pfin > 32'd1048575) begin
                        r_pout   <= 20'hfffff;
                        r_status <= ST_SAT;
                    end else begin
                        r_pout <= pfin[19:0];
                    end
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_valid;
    assign o_temperature = r_tout;
    assign o_pressure    = r_pout;
    assign o_status      = r_status;

    // checks
    `BC_ASSERT(a_status_code, i_clk, i_rst_n, o_valid |-> (o_status != 2'd3))
    `BC_ASSERT(a_divz_press, i_clk, i_rst_n, (o_valid && o_status == ST_DIVZ) |-> (o_pressure == 20'd0))
    `BC_ASSERT_NEXT(a_div_latency, i_clk, i_rst_n, div_start, !div_done)
    `BC_ASSERT(a_pop_idle, i_clk, i_rst_n, o_pop |-> !o_valid || (r_state == S_IDLE))
endmodule

// File: rtl/core/barometric_compensation_top.sv
// the back end works on one reading at a time: temperature steps, a serial
// division, the remaining temperature and pressure steps, a second serial
// division and the last pressure steps; a zero divisor ends a reading early
// a two-entry queue takes requests while a reading is in work; busy when full
// reset: synchronous active-low i_rst_n clears queue, sequencer and calibration registers
// results are strobed for one cycle and cannot be stalled
// ----------------------------------------------------------------------------
// barometric_compensation_top
// temperature and pressure compensation with integer calibration formulas
// ----------------------------------------------------------------------------
module barometric_compensation_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_we,
    input  logic [2:0]  i_addr,
    input  logic [31:0] i_wdata,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [15:0] i_raw_temp,
    input  logic [23:0] i_raw_press,
    output logic        o_valid,
    output logic [15:0] o_temperature,
    output logic [19:0] o_pressure,
    output logic [1:0]  o_status
);
    import bcomp_pkg::*;

    t_cal  r_cal;
    t_item item;
    logic  avail, pop;

    // calibration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_we) begin
            case (i_addr)
                REG_AC1_AC2: r_cal.ac1_ac2 <= i_wdata;
                REG_AC3_AC4: r_cal.ac3_ac4 <= i_wdata;
                REG_AC5_AC6: r_cal.ac5_ac6 <= i_wdata;
                REG_B1_B2:   r_cal.b1_b2   <= i_wdata;
                REG_MC_MD:   r_cal.mc_md   <= i_wdata;
                REG_OSS:     r_cal.oss     <= i_wdata[1:0];
                default: ;
            endcase
        end
    end

    bcomp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_raw_temp  (i_raw_temp),
        .i_raw_press (i_raw_press),
        .o_busy      (o_busy),
        .i_pop       (pop),
        .o_avail     (avail),
        .o_item      (item)
    );

    bcomp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cal         (r_cal),
        .i_avail       (avail),
        .i_item        (item),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .o_temperature (o_temperature),
        .o_pressure    (o_pressure),
        .o_status      (o_status)
    );
endmodule

// File: tb/barometric_compensation_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_compensation_checker
// watches configuration writes, accepted requests and result strobes, computes
// the compensated temperature and pressure for each request and compares them
// ----------------------------------------------------------------------------
module barometric_compensation_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_we,
    input  logic [2:0]  i_addr,
    input  logic [31:0] i_wdata,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [15:0] i_raw_temp,
    input  logic [23:0] i_raw_press,
    input  logic        i_valid,
    input  logic [15:0] i_temperature,
    input  logic [19:0] i_pressure,
    input  logic [1:0]  i_status,
    output int          o_errors,
    output int          o_pending
);
    import bcomp_pkg::*;

    typedef struct packed {
        logic [15:0] temperature;
        logic [19:0] pressure;
        logic [1:0]  status;
    } t_reading;

    t_cal     cal;
    t_reading readings_due[$];
    int       errors;

    assign o_errors  = errors;
    assign o_pending = readings_due.size();

    function automatic logic [31:0] ext16(input logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

    // signed divide truncating toward zero, wraps on -2^31 / -1
    function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ua;
        logic [31:0] ub;
        logic [31:0] q;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        q  = ua / ub;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic t_reading compensate(input t_cal c, input logic [15:0] ut_in,
                                            input logic [23:0] up_in);
        t_reading    r;
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] ut, up, x1, x2, x3, den, b5, t, b6, sq, b3, b4, b7, p, q;
        logic [1:0]  os;
        os  = c.oss;
        ac1 = ext16(c.ac1_ac2[31:16]);
        ac2 = ext16(c.ac1_ac2[15:0]);
        ac3 = ext16(c.ac3_ac4[31:16]);
        ac4 = {16'd0, c.ac3_ac4[15:0]};
        ac5 = {16'd0, c.ac5_ac6[31:16]};
        ac6 = {16'd0, c.ac5_ac6[15:0]};
        b1  = ext16(c.b1_b2[31:16]);
        b2  = ext16(c.b1_b2[15:0]);
        mc  = ext16(c.mc_md[31:16]);
        md  = ext16(c.mc_md[15:0]);
        ut  = {16'd0, ut_in};
        up  = {8'd0, up_in} >> (8 - os);
        r.status = ST_OK;
        x1  = div_trunc((ut - ac6) * ac5, 32'd32768);
        den = x1 + md;
        if (den == 0) begin
            r.temperature = '0;
            r.pressure    = '0;
            r.status      = ST_DIVZ;
            return r;
        end
        x2 = div_trunc(mc * 32'd2048, den);
        b5 = x1 + x2;
        t  = div_trunc(b5 + 32'd8, 32'd16);
        // saturate temperature
        if ($signed(t) < -32768) begin
            r.temperature = 16'h8000;
            r.status = ST_SAT;
        end else if ($signed(t) > 32767) begin
            r.temperature = 16'h7fff;
            r.status = ST_SAT;
        end else begin
            r.temperature = t[15:0];
        end
        b6 = b5 - 32'd4000;
        sq = div_trunc(b6 * b6, 32'd4096);
        x1 = div_trunc(b2 * sq, 32'd2048);
        x2 = div_trunc(ac2 * b6, 32'd2048);
        x3 = x1 + x2;
        b3 = div_trunc(((ac1 * 32'd4) + x3) * (32'd1 << os) + 32'd2, 32'd4);
        x1 = div_trunc(ac3 * b6, 32'd32768);
        x2 = div_trunc(b1 * sq, 32'd65536);
        x3 = div_trunc(x1 + x2 + 32'd2, 32'd4);
        b4 = (ac4 * (x3 + 32'd32768)) / 32'd32768;
        if (b4 == 0) begin
            r.pressure = '0;
            r.status   = ST_DIVZ;
            return r;
        end
        b7 = (up - b3) * (32'd50000 >> os);
        if (!b7[31]) p = (b7 * 32'd2) / b4;
        else p = (b7 / b4) * 32'd2;
        q  = div_trunc(p, 32'd256);
        x1 = div_trunc((q * q) * 32'd3038, 32'd65536);
        x2 = div_trunc((-32'd7357) * p, 32'd65536);
        p  = p + div_trunc(x1 + x2 + 32'd3791, 32'd16);
        // saturate pressure
        if (p[31]) begin
            r.pressure = '0;
            r.status = ST_SAT;
        end else if (p > 32'd1048575) begin
            r.pressure = 20'hfffff;
            r.status = ST_SAT;
        end else begin
            r.pressure = p[19:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    // register shadow, request prediction and result compare
    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            cal <= '0;
            readings_due.delete();
            errors <= 0;
        end else begin
            if (i_we) begin
                case (i_addr)
                    REG_AC1_AC2: cal.ac1_ac2 <= i_wdata;
                    REG_AC3_AC4: cal.ac3_ac4 <= i_wdata;
                    REG_AC5_AC6: cal.ac5_ac6 <= i_wdata;
                    REG_B1_B2:   cal.b1_b2   <= i_wdata;
                    REG_MC_MD:   cal.mc_md   <= i_wdata;
                    REG_OSS:     cal.oss     <= i_wdata[1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                readings_due.push_back(compensate(cal, i_raw_temp, i_raw_press));
            if (i_valid) begin
                if (readings_due.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    want = readings_due.pop_front();
                    if (i_temperature !== want.temperature)
                        report_mismatch("temperature", i_temperature, want.temperature);
                    if (i_pressure !== want.pressure)
                        report_mismatch("pressure", i_pressure, want.pressure);
                    if (i_status !== want.status)
                        report_mismatch("status", i_status, want.status);
                end
            end
        end
    end

endmodule

// File: tb/barometric_compensation_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_compensation_top_tb
// drives calibration sets and readings into the compensation block with random
// gaps; the checker predicts every result and counts mismatches
// ----------------------------------------------------------------------------
module barometric_compensation_top_tb;
    import bcomp_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_we;
    logic [2:0]  i_addr;
    logic [31:0] i_wdata;
    logic        i_start;
    logic        o_busy;
    logic [15:0] i_raw_temp;
    logic [23:0] i_raw_press;
    logic        o_valid;
    logic [15:0] o_temperature;
    logic [19:0] o_pressure;
    logic [1:0]  o_status;
    int          errors;
    int          pending;

    barometric_compensation_top i_dut (.*);

    barometric_compensation_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(i_we), .i_addr(i_addr),
        .i_wdata(i_wdata), .i_start(i_start), .i_busy(o_busy),
        .i_raw_temp(i_raw_temp), .i_raw_press(i_raw_press), .i_valid(o_valid),
        .i_temperature(o_temperature), .i_pressure(o_pressure),
        .i_status(o_status), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    // write enable stays high until the caller drops it
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        i_we    <= 1;
        i_addr  <= addr;
        i_wdata <= data;
        @(negedge i_clk);
    endtask

    // wait for all results plus the block's latency
    task automatic drain();
        i_start <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    task automatic idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return;
        i_start <= 0;
        if (r < 95) repeat ($urandom_range(1, 4)) @(negedge i_clk);
        else repeat ($urandom_range(20, 200)) @(negedge i_clk);
    endtask

    // one request, held while o_busy is high; start stays high for a following request
    task automatic send_reading(input logic [15:0] ut, input logic [23:0] up);
        i_start     <= 1;
        i_raw_temp  <= ut;
        i_raw_press <= up;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic load_cal(input logic [31:0] a, b, c, d, e, input logic [1:0] os);
        drain();
        write_reg(REG_AC1_AC2, a);
        write_reg(REG_AC3_AC4, b);
        write_reg(REG_AC5_AC6, c);
        write_reg(REG_B1_B2, d);
        write_reg(REG_MC_MD, e);
        write_reg(REG_OSS, {30'd0, os});
        i_we <= 0;
    endtask

    // calibration near the datasheet example, with random spread
    task automatic typical_cal();
        load_cal({16'd408 + 16'($urandom_range(0, 200)), -16'sd72},
                 {-16'sd14383, 16'd32741 + 16'($urandom_range(0, 500))},
                 {16'd32757, 16'd23153 + 16'($urandom_range(0, 300))},
                 {16'd6190, 16'd4},
                 {-16'sd8711 + 16'($urandom_range(0, 100)), 16'd2868},
                 2'($urandom_range(0, 3)));
    endtask

    initial begin
        i_rst_n = 0; i_we = 0; i_addr = '0; i_wdata = '0;
        i_start = 0; i_raw_temp = '0; i_raw_press = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // all-zero calibration: temperature divisor zero
        send_reading(16'h0000, 24'h000000);
        send_reading(16'hffff, 24'hffffff);
        // pressure divisor zero (ac4 zero)
        load_cal({16'd408, -16'sd72}, {-16'sd14383, 16'd0}, {16'd32757, 16'd23153},
                 {16'd6190, 16'd4}, {-16'sd8711, 16'd2868}, 2'd0);
        send_reading(16'd27898, 24'h5d2300);
        // datasheet example and extremes
        load_cal({16'd408, -16'sd72}, {-16'sd14383, 16'd32741}, {16'd32757, 16'd23153},
                 {16'd6190, 16'd4}, {-16'sd8711, 16'd2868}, 2'd0);
        send_reading(16'd27898, 24'h5d2300);
        send_reading(16'h0000, 24'h000000);
        send_reading(16'hffff, 24'hffffff);
        send_reading(16'h8000, 24'h800000);
        // extreme coefficients, saturation and wrap
        load_cal(32'h7fff_8000, 32'h8000_ffff, 32'hffff_ffff, 32'h7fff_8000,
                 32'h8000_7fff, 2'd3);
        send_reading(16'h0000, 24'hffffff);
        send_reading(16'hffff, 24'h000000);
        send_reading(16'h5555, 24'haaaaaa);
        load_cal(32'h8000_7fff, 32'h7fff_0001, 32'h0001_0000, 32'h8000_7fff,
                 32'h7fff_8000, 2'd1);
        send_reading(16'h1234, 24'h123456);
        send_reading(16'hfedc, 24'hfedcba);
        // ignored register index
        drain();
        write_reg(3'd6, 32'hffff_ffff);
        write_reg(3'd7, 32'h0);
        i_we <= 0;
        send_reading(16'h7fff, 24'h7fffff);

        for (int ph = 0; ph < 16; ph++) begin
            if (ph % 4 == 3)
                load_cal($urandom, $urandom, $urandom, $urandom, $urandom,
                         2'($urandom_range(0, 3)));
            else
                typical_cal();
            for (int n = 0; n < 100; n++) begin
                idle_gap();
                if ($urandom_range(0, 9) < 8)
                    send_reading(16'd20000 + 16'($urandom_range(0, 20000)),
                                 24'($urandom_range(24'h400000, 24'hb00000)));
                else
                    send_reading(16'($urandom), 24'($urandom));
            end
        end
        drain();
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
